/* hw/rtl/lcls_pkg.sv */
package lcls_pkg;

   localparam int CUBE_SIDE = 8;
   localparam int PLANE = 8;
   localparam int COORD_W = 3;
   localparam int BYTE_W = 8;
   localparam int ROW_W = PLANE * BYTE_W;
   localparam int ROW_ORDER_W = PLANE * COORD_W;
   localparam logic [ROW_ORDER_W-1:0] ROW_ORDER_RESET = ROW_ORDER_W'(5498056);

   typedef enum logic [1:0] {
      REQ_WRITE  = 2'd0,
      REQ_CLEAR  = 2'd1,
      REQ_COMMIT = 2'd2,
      REQ_TICK   = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WR_READ,
      ST_WR_BACK,
      ST_CM_READ,
      ST_CM_WRITE,
      ST_TK_READ,
      ST_TK_EMIT
   } state_type;

   typedef struct packed {
      logic load_req;
      logic clear_draft;
      logic draft_read;
      logic draft_write;
      logic draft_use_count;
      logic shown_read;
      logic shown_write;
      logic step_layer;
      logic count_clear;
      logic count_inc;
      logic rsp_valid;
   } cmd_type;

   typedef struct packed {
      logic last_row;
      logic last_copy;
   } status_type;

endpackage

/* hw/rtl/led_cube_layer_scan_refresh.sv */
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  type, coord_x/y/z, led_on
// rsp_      out        rsp_valid/rsp_ready  layer, row_address, column_bits, last_row
// csr_      in         csr_wr_en            row_order
//
// A LED write reads, modifies and writes back one draft row, a draft clear empties
// the draft, and a commit moves it one 64-bit plane row at a time through the draft
// memory port. A refresh tick reads the next layer and emits its rows as row beats.
// One item is in flight at a time; req_ready is low until it is finished.
// Reset is synchronous and needs no clearing pass; both stores read as zero.
// A stall on rsp_ready holds the current row beat and the whole block.
module led_cube_layer_scan_refresh (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_type,
   input  logic [lcls_pkg::COORD_W-1:0]          req_coord_x,
   input  logic [lcls_pkg::COORD_W-1:0]          req_coord_y,
   input  logic [lcls_pkg::COORD_W-1:0]          req_coord_z,
   input  logic                                  req_led_on,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [lcls_pkg::COORD_W-1:0]          rsp_layer,
   output logic [lcls_pkg::COORD_W-1:0]          rsp_row_address,
   output logic [lcls_pkg::BYTE_W-1:0]           rsp_column_bits,
   output logic                                  rsp_last_row,
   input  logic                                  csr_wr_en,
   input  logic [lcls_pkg::ROW_ORDER_W-1:0]      csr_wr_data
);

   lcls_pkg::cmd_type    cmd;
   lcls_pkg::status_type status;

   lcls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lcls_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .req_led_on      (req_led_on),
      .rsp_layer       (rsp_layer),
      .rsp_row_address (rsp_row_address),
      .rsp_column_bits (rsp_column_bits),
      .rsp_last_row    (rsp_last_row)
   );

   assign rsp_valid = cmd.rsp_valid;

endmodule

/* hw/rtl/lcls_ctrl.sv */
module lcls_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_type,
   input  logic                  rsp_ready,
   input  lcls_pkg::status_type  status,
   output lcls_pkg::cmd_type     cmd
);

   lcls_pkg::state_type state_ff, state_in;
   logic                accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcls_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      accept    = 1'b0;
      unique case (state_ff)
         lcls_pkg::ST_IDLE: begin
            req_ready = !reset;
            accept    = req_valid && !reset;
            if (accept) begin
               cmd.load_req = 1'b1;
               unique case (lcls_pkg::req_code_type'(req_type))
                  lcls_pkg::REQ_WRITE: begin
                     state_in = lcls_pkg::ST_WR_READ;
                  end
                  lcls_pkg::REQ_CLEAR: begin
                     cmd.clear_draft = 1'b1;
                  end
                  lcls_pkg::REQ_COMMIT: begin
                     cmd.count_clear = 1'b1;
                     state_in        = lcls_pkg::ST_CM_READ;
                  end
                  lcls_pkg::REQ_TICK: begin
                     cmd.count_clear = 1'b1;
                     cmd.step_layer  = 1'b1;
                     state_in        = lcls_pkg::ST_TK_READ;
                  end
               endcase
            end
         end
         lcls_pkg::ST_WR_READ: begin
            cmd.draft_read = 1'b1;
            state_in       = lcls_pkg::ST_WR_BACK;
         end
         lcls_pkg::ST_WR_BACK: begin
            cmd.draft_write = 1'b1;
            state_in        = lcls_pkg::ST_IDLE;
         end
         lcls_pkg::ST_CM_READ: begin
            cmd.draft_read      = 1'b1;
            cmd.draft_use_count = 1'b1;
            state_in            = lcls_pkg::ST_CM_WRITE;
         end
         lcls_pkg::ST_CM_WRITE: begin
            cmd.shown_write = 1'b1;
            cmd.count_inc   = 1'b1;
            if (status.last_copy) begin
               state_in = lcls_pkg::ST_IDLE;
            end else begin
               state_in = lcls_pkg::ST_CM_READ;
            end
         end
         lcls_pkg::ST_TK_READ: begin
            cmd.shown_read = 1'b1;
            state_in       = lcls_pkg::ST_TK_EMIT;
         end
         lcls_pkg::ST_TK_EMIT: begin
            cmd.rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.count_inc = 1'b1;
               if (status.last_row) begin
                  state_in = lcls_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = lcls_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* hw/rtl/lcls_dp.sv */
module lcls_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lcls_pkg::cmd_type                     cmd,
   output lcls_pkg::status_type                  status,
   input  logic                                  csr_wr_en,
   input  logic [lcls_pkg::ROW_ORDER_W-1:0]      csr_wr_data,
   input  logic [lcls_pkg::COORD_W-1:0]          req_coord_x,
   input  logic [lcls_pkg::COORD_W-1:0]          req_coord_y,
   input  logic [lcls_pkg::COORD_W-1:0]          req_coord_z,
   input  logic                                  req_led_on,
   output logic [lcls_pkg::COORD_W-1:0]          rsp_layer,
   output logic [lcls_pkg::COORD_W-1:0]          rsp_row_address,
   output logic [lcls_pkg::BYTE_W-1:0]           rsp_column_bits,
   output logic                                  rsp_last_row
);

   localparam int CW = lcls_pkg::COORD_W;
   localparam int RW = lcls_pkg::ROW_W;
   localparam int PL = lcls_pkg::PLANE;

   logic [lcls_pkg::ROW_ORDER_W-1:0] row_order_ff;
   logic [CW-1:0]                    x_ff, y_ff, z_ff;
   logic                             on_ff;
   logic [CW-1:0]                    layer_ff;
   logic [CW-1:0]                    count_ff;

   logic [RW-1:0] draft_mem [PL];
   logic [RW-1:0] shown_mem [PL];
   logic [PL-1:0] draft_vld_ff;
   logic [PL-1:0] shown_vld_ff;
   logic [RW-1:0] draft_rd_ff;
   logic          draft_rd_vld_ff;
   logic [RW-1:0] shown_rd_ff;
   logic          shown_rd_vld_ff;

   logic [CW-1:0] draft_addr;
   logic [RW-1:0] draft_row;
   logic [RW-1:0] draft_mod;
   logic [RW-1:0] shown_row;
   logic          on_cube;
   logic [CW-1:0] row_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_order_ff <= lcls_pkg::ROW_ORDER_RESET;
      end else if (csr_wr_en) begin
         row_order_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         x_ff  <= req_coord_x;
         y_ff  <= req_coord_y;
         z_ff  <= req_coord_z;
         on_ff <= req_led_on;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_ff <= CW'(lcls_pkg::CUBE_SIDE - 1);
      end else if (cmd.step_layer) begin
         if (int'(layer_ff) >= lcls_pkg::CUBE_SIDE - 1) begin
            layer_ff <= '0;
         end else begin
            layer_ff <= layer_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.count_clear) begin
         count_ff <= '0;
      end else if (cmd.count_inc) begin
         count_ff <= count_ff + CW'(1);
      end
   end

   assign status.last_row  = (int'(count_ff) == lcls_pkg::CUBE_SIDE - 1);
   assign status.last_copy = (int'(count_ff) == PL - 1);

   assign draft_addr = cmd.draft_use_count ? count_ff : z_ff;
   assign draft_row  = draft_rd_vld_ff ? draft_rd_ff : '0;
   assign on_cube    = (int'(x_ff) < lcls_pkg::CUBE_SIDE) &&
                       (int'(y_ff) < lcls_pkg::CUBE_SIDE) &&
                       (int'(z_ff) < lcls_pkg::CUBE_SIDE);

   always_comb begin
      draft_mod = draft_row;
      draft_mod[{y_ff, x_ff}] = on_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.draft_write && on_cube) begin
         draft_mem[z_ff] <= draft_mod;
      end
      if (cmd.draft_read) begin
         draft_rd_ff <= draft_mem[draft_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         draft_vld_ff    <= '0;
         draft_rd_vld_ff <= 1'b0;
      end else begin
         if (cmd.clear_draft) begin
            draft_vld_ff <= '0;
         end else if (cmd.draft_write && on_cube) begin
            draft_vld_ff[z_ff] <= 1'b1;
         end
         if (cmd.draft_read) begin
            draft_rd_vld_ff <= draft_vld_ff[draft_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.shown_write) begin
         shown_mem[count_ff] <= draft_row;
      end
      if (cmd.shown_read) begin
         shown_rd_ff <= shown_mem[layer_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shown_vld_ff    <= '0;
         shown_rd_vld_ff <= 1'b0;
      end else begin
         if (cmd.shown_write) begin
            shown_vld_ff[count_ff] <= 1'b1;
         end
         if (cmd.shown_read) begin
            shown_rd_vld_ff <= shown_vld_ff[layer_ff];
         end
      end
   end

   assign shown_row = shown_rd_vld_ff ? shown_rd_ff : '0;
   assign row_addr  = row_order_ff[CW * int'(count_ff) +: CW];

   always_comb begin
      rsp_column_bits = '0;
      for (int d = 0; d < lcls_pkg::BYTE_W; d++) begin
         if (d < lcls_pkg::CUBE_SIDE) begin
            rsp_column_bits[d] = shown_row[{CW'(d), row_addr}];
         end
      end
   end

   assign rsp_layer       = layer_ff;
   assign rsp_row_address = row_addr;
   assign rsp_last_row    = status.last_row;

endmodule

/* hw/rtl/lcls_checker.sv */
module lcls_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic [1:0]                            req_type,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [lcls_pkg::COORD_W-1:0]          rsp_layer,
   input logic [lcls_pkg::COORD_W-1:0]          rsp_row_address,
   input logic [lcls_pkg::BYTE_W-1:0]           rsp_column_bits,
   input logic                                  rsp_last_row
);

   // The block never takes a request while a row beat is pending.
   a_no_req_during_rsp : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a row beat is pending");

   // A request other than a refresh tick produces no row beat right after it.
   a_no_rsp_after_edit : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_type != lcls_pkg::REQ_TICK)) |=> !rsp_valid)
      else $error("row beat after a non-tick request");

   // Rows of one layer follow each other without a gap and keep the layer.
   a_rows_contiguous : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_row) |=>
         (rsp_valid && (rsp_layer == $past(rsp_layer))))
      else $error("row sequence broken within a layer");

   // The last row of a layer ends the output burst.
   a_last_ends_burst : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_row) |=> !rsp_valid)
      else $error("row beat after the last row");

   // A stalled row beat holds its payload.
   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_row_address) && $stable(rsp_column_bits)
          && $stable(rsp_layer) && $stable(rsp_last_row)))
      else $error("stalled row beat changed");

endmodule

bind led_cube_layer_scan_refresh lcls_checker u_lcls_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_type        (req_type),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_layer       (rsp_layer),
   .rsp_row_address (rsp_row_address),
   .rsp_column_bits (rsp_column_bits),
   .rsp_last_row    (rsp_last_row)
);

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

   localparam int TIMEOUT_CYCLES = 400000;
   localparam logic [lcls_pkg::ROW_ORDER_W-1:0] ROW_ORDER_LINEAR = 24'hFAC688;

   class scan_scoreboard;
      typedef struct packed {
         logic [2:0] layer;
         logic [2:0] row_address;
         logic [7:0] column_bits;
         logic       last_row;
      } scan_row_type;

      logic [7:0]   draft [8][8];
      logic [7:0]   shown [8][8];
      logic [2:0]   layer_count;
      logic [23:0]  row_order;
      scan_row_type pending_rows[$];
      int           errors;

      function new();
         foreach (draft[a, b]) begin
            draft[a][b] = '0;
            shown[a][b] = '0;
         end
         layer_count = 3'd7;
         row_order = lcls_pkg::ROW_ORDER_RESET;
         errors = 0;
      endfunction

      function void set_row_order(logic [23:0] value);
         row_order = value;
      endfunction

      function int pending();
         return pending_rows.size();
      endfunction

      function void note_request(lcls_pkg::req_code_type kind, logic [2:0] x,
                                 logic [2:0] y, logic [2:0] z, logic on);
         scan_row_type row;
         logic [2:0]   addr;
         case (kind)
            lcls_pkg::REQ_WRITE: begin
               draft[y][z][x] = on;
            end
            lcls_pkg::REQ_CLEAR: begin
               foreach (draft[a, b]) draft[a][b] = '0;
            end
            lcls_pkg::REQ_COMMIT: begin
               shown = draft;
            end
            lcls_pkg::REQ_TICK: begin
               if (layer_count == 3'(lcls_pkg::CUBE_SIDE - 1)) begin
                  layer_count = 3'd0;
               end else begin
                  layer_count = layer_count + 3'd1;
               end
               for (int r = 0; r < lcls_pkg::CUBE_SIDE; r++) begin
                  addr = row_order[3*r +: 3];
                  row.layer = layer_count;
                  row.row_address = addr;
                  row.column_bits = '0;
                  for (int d = 0; d < lcls_pkg::CUBE_SIDE; d++) begin
                     row.column_bits[d] = shown[d][layer_count][addr];
                  end
                  row.last_row = (r == lcls_pkg::CUBE_SIDE - 1);
                  pending_rows.push_back(row);
               end
            end
         endcase
      endfunction

      function void compare_field(string name, int expected, int actual);
         if (expected != actual) begin
            $error("%s expected %0d got %0d", name, expected, actual);
            errors++;
         end
      endfunction

      function void check_row(logic [2:0] layer, logic [2:0] row_address,
                              logic [7:0] column_bits, logic last_row);
         scan_row_type want;
         if (pending_rows.size() == 0) begin
            $error("row beat with nothing expected: layer %0d row_address %0d", layer,
                   row_address);
            errors++;
         end else begin
            want = pending_rows.pop_front();
            compare_field("layer", want.layer, layer);
            compare_field("row_address", want.row_address, row_address);
            compare_field("column_bits", want.column_bits, column_bits);
            compare_field("last_row", want.last_row, last_row);
         end
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [1:0]                       req_type = lcls_pkg::REQ_WRITE;
   logic [lcls_pkg::COORD_W-1:0]     req_coord_x = '0;
   logic [lcls_pkg::COORD_W-1:0]     req_coord_y = '0;
   logic [lcls_pkg::COORD_W-1:0]     req_coord_z = '0;
   logic                             req_led_on = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [lcls_pkg::COORD_W-1:0]     rsp_layer;
   logic [lcls_pkg::COORD_W-1:0]     rsp_row_address;
   logic [lcls_pkg::BYTE_W-1:0]      rsp_column_bits;
   logic                             rsp_last_row;
   logic                             csr_wr_en = 1'b0;
   logic [lcls_pkg::ROW_ORDER_W-1:0] csr_wr_data = '0;

   scan_scoreboard board = new();
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_cycles = 0;
   int cycle_count = 0;

   led_cube_layer_scan_refresh dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .req_led_on      (req_led_on),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_layer       (rsp_layer),
      .rsp_row_address (rsp_row_address),
      .rsp_column_bits (rsp_column_bits),
      .rsp_last_row    (rsp_last_row),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > TIMEOUT_CYCLES) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // The receiver takes row beats and, when a hold is requested, keeps ready low until
   // the hold count runs down, regardless of the random stall rate.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            board.check_row(rsp_layer, rsp_row_address, rsp_column_bits, rsp_last_row);
         end
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic send_item(lcls_pkg::req_code_type kind, logic [2:0] x, logic [2:0] y,
                            logic [2:0] z, logic on);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      req_led_on <= on;
      do @(posedge clock); while (!req_ready);
      board.note_request(kind, x, y, z, on);
   endtask

   task automatic send_kind(lcls_pkg::req_code_type kind);
      send_item(kind, 3'($urandom_range(7)), 3'($urandom_range(7)), 3'($urandom_range(7)),
                1'($urandom_range(3) != 0));
   endtask

   task automatic run_random(int count);
      int sent;
      int writes;
      int ticks;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(9) < 8) begin
            if ($urandom_range(5) == 0) begin
               send_kind(lcls_pkg::REQ_CLEAR);
               sent++;
            end
            writes = $urandom_range(12, 1);
            repeat (writes) send_kind(lcls_pkg::REQ_WRITE);
            send_kind(lcls_pkg::REQ_COMMIT);
            ticks = $urandom_range(4, 1);
            repeat (ticks) send_kind(lcls_pkg::REQ_TICK);
            sent += writes + 1 + ticks;
         end else begin
            send_kind(lcls_pkg::req_code_type'($urandom_range(3)));
            sent++;
         end
      end
   endtask

   task automatic write_row_order(logic [lcls_pkg::ROW_ORDER_W-1:0] value);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.set_row_order(value);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_item(lcls_pkg::REQ_TICK, 3'd0, 3'd0, 3'd0, 1'b0);
      send_item(lcls_pkg::REQ_WRITE, 3'd0, 3'd0, 3'd0, 1'b1);
      send_item(lcls_pkg::REQ_WRITE, 3'd7, 3'd7, 3'd7, 1'b1);
      send_item(lcls_pkg::REQ_WRITE, 3'd7, 3'd0, 3'd7, 1'b1);
      send_item(lcls_pkg::REQ_WRITE, 3'd0, 3'd7, 3'd0, 1'b1);
      send_item(lcls_pkg::REQ_WRITE, 3'd5, 3'd3, 3'd0, 1'b1);
      send_item(lcls_pkg::REQ_WRITE, 3'd2, 3'd7, 3'd7, 1'b1);
      send_item(lcls_pkg::REQ_WRITE, 3'd7, 3'd7, 3'd7, 1'b0);
      send_item(lcls_pkg::REQ_COMMIT, 3'd7, 3'd7, 3'd7, 1'b1);
      repeat (8) send_item(lcls_pkg::REQ_TICK, 3'd7, 3'd0, 3'd7, 1'b1);
      send_item(lcls_pkg::REQ_CLEAR, 3'd0, 3'd7, 3'd0, 1'b0);
      send_item(lcls_pkg::REQ_TICK, 3'd0, 3'd0, 3'd0, 1'b0);
      send_item(lcls_pkg::REQ_COMMIT, 3'd0, 3'd0, 3'd0, 1'b0);
      send_item(lcls_pkg::REQ_TICK, 3'd0, 3'd0, 3'd0, 1'b0);

      write_row_order(24'hFFFFFF);
      run_random(26);

      write_row_order(24'h000000);
      send_idle_pct = 88;
      run_random(26);

      write_row_order(ROW_ORDER_LINEAR);
      send_idle_pct = 0;
      stall_pct = 88;
      run_random(26);

      write_row_order(lcls_pkg::ROW_ORDER_W'($urandom_range(24'hFFFFFF)));
      send_idle_pct = 9;
      stall_pct = 9;
      run_random(26);

      // Long receiver hold while the sender keeps offering, so the block backs up.
      write_row_order(lcls_pkg::ROW_ORDER_RESET);
      send_idle_pct = 0;
      stall_pct = 0;
      hold_cycles = 400;
      send_kind(lcls_pkg::REQ_TICK);
      send_kind(lcls_pkg::REQ_TICK);
      run_random(12);

      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
